// ----- sv/terminal_escape_key_decoder_assert.svh -----
// assertion macros for the terminal escape key decoder
`ifndef TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define TEKD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tekd assertion failed");
`define TEKD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tekd assertion failed");
`else
`define TEKD_ASSERT_IMP(label, clk, rst, ante, cons)
`define TEKD_ASSERT_NEXT(label, clk, ante, cons)
`endif

`endif

// ----- sv/tekd_pkg.sv -----
// types and constants shared by the terminal escape key decoder
package tekd_pkg;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       more_pending;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] char_out;
      logic [3:0] key_id;
   } rsp_type;

   // result of one parse step, handed to the output stage
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } parse_result_type;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_ESC    = 2'd1,
      PHASE_INTRO  = 2'd2,
      PHASE_DIGITS = 2'd3
   } phase_type;

   localparam logic [1:0] EVENT_NONE    = 2'd0;
   localparam logic [1:0] EVENT_CHAR    = 2'd1;
   localparam logic [1:0] EVENT_SPECIAL = 2'd2;

   localparam logic [3:0] KEY_UP     = 4'd0;
   localparam logic [3:0] KEY_DOWN   = 4'd1;
   localparam logic [3:0] KEY_RIGHT  = 4'd2;
   localparam logic [3:0] KEY_LEFT   = 4'd3;
   localparam logic [3:0] KEY_HOME   = 4'd4;
   localparam logic [3:0] KEY_END    = 4'd5;
   localparam logic [3:0] KEY_INSERT = 4'd6;
   localparam logic [3:0] KEY_DELETE = 4'd7;
   localparam logic [3:0] KEY_PGUP   = 4'd8;
   localparam logic [3:0] KEY_PGDN   = 4'd9;

   localparam logic [7:0] CHAR_ESC     = 8'h1B;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_BRACKET = 8'h5B;
   localparam logic [7:0] CHAR_SS3     = 8'h4F;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_B       = 8'h42;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_D       = 8'h44;
   localparam logic [7:0] CHAR_H       = 8'h48;
   localparam logic [7:0] CHAR_F       = 8'h46;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [6:0] NUM_INSERT = 7'd2;
   localparam logic [6:0] NUM_DELETE = 7'd3;
   localparam logic [6:0] NUM_PGUP   = 7'd5;
   localparam logic [6:0] NUM_PGDN   = 7'd6;
   localparam logic [6:0] NUM_MAX    = 7'd99;

endpackage

// ----- sv/terminal_escape_key_decoder.sv -----
// top level of the terminal escape key decoder
//
// Takes one terminal byte per item on the req_ channel, together with a flag
// telling whether another byte already waits behind it, and gives key events
// on the rsp_ channel: plain characters (CR turned into LF), ESC-prefixed
// characters, arrow, Home, End, Insert, Delete, PageUp and PageDown keys.
// Bytes that only advance an escape sequence give no event; an unknown
// sequence gives one event of kind none.
// The byte is registered on acceptance, decoded from the input register
// against the parse phase and number registers, and the event is registered:
// an event reaches rsp_valid through the input and event registers.
// Throughput is one byte per cycle unless rsp_ stalls (single decode stage).
// A stall on rsp_ holds the event register; the input register then holds
// its byte and req_stall rises, so at most two items sit in the block.
// Reset (synchronous) empties both registers and returns the parser to idle
// with a zero number.
`include "terminal_escape_key_decoder_assert.svh"

module terminal_escape_key_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tekd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tekd_pkg::rsp_type rsp_data
);

   logic                       item_valid;
   tekd_pkg::req_type          item;
   tekd_pkg::parse_result_type result;
   logic                       advance;
   logic                       out_blocked;
   logic                       key_shown;
   logic                       char_shown;
   logic                       is_special;
   logic                       is_char;

   // the decode step moves when the event register is free or being emptied
   assign advance = item_valid && (!rsp_valid || !rsp_stall);

   tekd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tekd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   tekd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign out_blocked = rsp_valid && rsp_stall;
   assign key_shown   = rsp_valid && (rsp_data.key_id != 4'd0);
   assign char_shown  = rsp_valid && (rsp_data.char_out != 8'd0);
   assign is_special  = (rsp_data.event_kind == tekd_pkg::EVENT_SPECIAL);
   assign is_char     = (rsp_data.event_kind == tekd_pkg::EVENT_CHAR);

   `TEKD_ASSERT_IMP(a_stall_only_when_full, clock, reset, req_stall, item_valid && out_blocked)
   `TEKD_ASSERT_IMP(a_key_only_on_special, clock, reset, key_shown, is_special)
   `TEKD_ASSERT_IMP(a_char_only_on_char, clock, reset, char_shown, is_char)
   `TEKD_ASSERT_NEXT(a_empty_after_reset, clock, reset, !rsp_valid && !req_stall)

endmodule

// ----- sv/tekd_in_reg.sv -----
// input register of the terminal escape key decoder
module tekd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tekd_pkg::req_type req_data,
   input  logic              advance,
   output logic              item_valid,
   output tekd_pkg::req_type item
);

   logic              valid_ff, valid_in;
   tekd_pkg::req_type item_ff;
   logic              accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- sv/tekd_parser.sv -----
// escape sequence state machine: phase and number registers plus decode
module tekd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  tekd_pkg::req_type          item,
   output tekd_pkg::parse_result_type result
);

   tekd_pkg::phase_type phase_ff, phase_in;
   logic [6:0]          number_ff, number_in;
   logic                is_digit;
   logic [7:0]          digit_diff;
   logic [3:0]          digit_val;
   logic [9:0]          number_next;

   assign is_digit   = (item.byte_in >= tekd_pkg::CHAR_ZERO) &&
                       (item.byte_in <= tekd_pkg::CHAR_NINE);
   assign digit_diff = item.byte_in - tekd_pkg::CHAR_ZERO;
   assign digit_val  = digit_diff[3:0];
   // number * 10 + digit, at most 999
   assign number_next = ({3'b000, number_ff} << 3) + ({3'b000, number_ff} << 1) +
                        {6'b000000, digit_val};

   // next state
   always_comb begin
      phase_in  = phase_ff;
      number_in = number_ff;
      case (phase_ff)
         tekd_pkg::PHASE_IDLE: begin
            if (item.byte_in == tekd_pkg::CHAR_ESC && item.more_pending) begin
               phase_in = tekd_pkg::PHASE_ESC;
            end
         end
         tekd_pkg::PHASE_ESC: begin
            if (item.byte_in == tekd_pkg::CHAR_BRACKET ||
                item.byte_in == tekd_pkg::CHAR_SS3) begin
               phase_in = tekd_pkg::PHASE_INTRO;
            end else begin
               phase_in = tekd_pkg::PHASE_IDLE;
            end
         end
         tekd_pkg::PHASE_INTRO: begin
            if (is_digit) begin
               phase_in  = tekd_pkg::PHASE_DIGITS;
               number_in = {3'b000, digit_val};
            end else begin
               phase_in = tekd_pkg::PHASE_IDLE;
            end
         end
         tekd_pkg::PHASE_DIGITS: begin
            if (is_digit) begin
               if (number_next > {3'b000, tekd_pkg::NUM_MAX}) begin
                  number_in = tekd_pkg::NUM_MAX;
               end else begin
                  number_in = number_next[6:0];
               end
            end else begin
               phase_in = tekd_pkg::PHASE_IDLE;
            end
         end
         default: begin
            phase_in = tekd_pkg::PHASE_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      result = '0;
      case (phase_ff)
         tekd_pkg::PHASE_IDLE: begin
            if (!(item.byte_in == tekd_pkg::CHAR_ESC && item.more_pending)) begin
               result.valid           = 1'b1;
               result.data.event_kind = tekd_pkg::EVENT_CHAR;
               result.data.char_out   = (item.byte_in == tekd_pkg::CHAR_CR) ?
                                        tekd_pkg::CHAR_LF : item.byte_in;
            end
         end
         tekd_pkg::PHASE_ESC: begin
            if (!(item.byte_in == tekd_pkg::CHAR_BRACKET ||
                  item.byte_in == tekd_pkg::CHAR_SS3)) begin
               result.valid           = 1'b1;
               result.data.event_kind = tekd_pkg::EVENT_CHAR;
               result.data.char_out   = item.byte_in;
            end
         end
         tekd_pkg::PHASE_INTRO: begin
            if (!is_digit) begin
               result.valid           = 1'b1;
               result.data.event_kind = tekd_pkg::EVENT_SPECIAL;
               case (item.byte_in)
                  tekd_pkg::CHAR_A: result.data.key_id = tekd_pkg::KEY_UP;
                  tekd_pkg::CHAR_B: result.data.key_id = tekd_pkg::KEY_DOWN;
                  tekd_pkg::CHAR_C: result.data.key_id = tekd_pkg::KEY_RIGHT;
                  tekd_pkg::CHAR_D: result.data.key_id = tekd_pkg::KEY_LEFT;
                  tekd_pkg::CHAR_H: result.data.key_id = tekd_pkg::KEY_HOME;
                  tekd_pkg::CHAR_F: result.data.key_id = tekd_pkg::KEY_END;
                  default: begin
                     result.data.event_kind = tekd_pkg::EVENT_NONE;
                  end
               endcase
            end
         end
         tekd_pkg::PHASE_DIGITS: begin
            // the terminating byte itself is dropped
            if (!is_digit) begin
               result.valid           = 1'b1;
               result.data.event_kind = tekd_pkg::EVENT_SPECIAL;
               case (number_ff)
                  tekd_pkg::NUM_INSERT: result.data.key_id = tekd_pkg::KEY_INSERT;
                  tekd_pkg::NUM_DELETE: result.data.key_id = tekd_pkg::KEY_DELETE;
                  tekd_pkg::NUM_PGUP:   result.data.key_id = tekd_pkg::KEY_PGUP;
                  tekd_pkg::NUM_PGDN:   result.data.key_id = tekd_pkg::KEY_PGDN;
                  default: begin
                     result.data.event_kind = tekd_pkg::EVENT_NONE;
                  end
               endcase
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= tekd_pkg::PHASE_IDLE;
         number_ff <= 7'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         number_ff <= number_in;
      end
   end

endmodule

// ----- sv/tekd_out_reg.sv -----
// result register of the terminal escape key decoder
module tekd_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  tekd_pkg::parse_result_type result,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tekd_pkg::rsp_type          rsp_data
);

   logic              valid_ff, valid_in;
   tekd_pkg::rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = result.valid;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- sim/terminal_escape_key_decoder_tb.sv -----
// testbench for the terminal escape key decoder: byte streams in, key events checked in order
`timescale 1ns / 1ps

module terminal_escape_key_decoder_tb;

   localparam int RANDOM_ITEMS = 550;
   localparam int QUIET_ITEMS  = 100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 60;

   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   class key_event_tracker;
      tekd_pkg::rsp_type   expected_events[$];
      tekd_pkg::phase_type phase;
      logic [6:0]          number;
      int                  mismatches;
      int                  bytes_seen;
      int                  events_checked;
      int                  char_events;
      int                  key_events;
      int                  none_events;
      bit                  key_hit[10];

      function new();
         phase  = tekd_pkg::PHASE_IDLE;
         number = '0;
      endfunction

      // advances the parse state by one byte, returns 1 when an event comes out
      function bit decode_byte(input tekd_pkg::req_type item, output tekd_pkg::rsp_type ev);
         logic [7:0] b;
         bit         is_digit;
         int         n;
         b        = item.byte_in;
         is_digit = (b >= tekd_pkg::CHAR_ZERO) && (b <= tekd_pkg::CHAR_NINE);
         ev       = '0;
         case (phase)
            tekd_pkg::PHASE_IDLE: begin
               if (b == tekd_pkg::CHAR_ESC && item.more_pending) begin
                  phase = tekd_pkg::PHASE_ESC;
                  return 1'b0;
               end
               ev.event_kind = tekd_pkg::EVENT_CHAR;
               ev.char_out   = (b == tekd_pkg::CHAR_CR) ? tekd_pkg::CHAR_LF : b;
               return 1'b1;
            end
            tekd_pkg::PHASE_ESC: begin
               if (b == tekd_pkg::CHAR_BRACKET || b == tekd_pkg::CHAR_SS3) begin
                  phase = tekd_pkg::PHASE_INTRO;
                  return 1'b0;
               end
               phase         = tekd_pkg::PHASE_IDLE;
               ev.event_kind = tekd_pkg::EVENT_CHAR;
               ev.char_out   = b;
               return 1'b1;
            end
            tekd_pkg::PHASE_INTRO: begin
               if (is_digit) begin
                  number = 7'(b - tekd_pkg::CHAR_ZERO);
                  phase  = tekd_pkg::PHASE_DIGITS;
                  return 1'b0;
               end
               phase         = tekd_pkg::PHASE_IDLE;
               ev.event_kind = tekd_pkg::EVENT_SPECIAL;
               case (b)
                  tekd_pkg::CHAR_A: ev.key_id = tekd_pkg::KEY_UP;
                  tekd_pkg::CHAR_B: ev.key_id = tekd_pkg::KEY_DOWN;
                  tekd_pkg::CHAR_C: ev.key_id = tekd_pkg::KEY_RIGHT;
                  tekd_pkg::CHAR_D: ev.key_id = tekd_pkg::KEY_LEFT;
                  tekd_pkg::CHAR_H: ev.key_id = tekd_pkg::KEY_HOME;
                  tekd_pkg::CHAR_F: ev.key_id = tekd_pkg::KEY_END;
                  default: ev.event_kind = tekd_pkg::EVENT_NONE;
               endcase
               return 1'b1;
            end
            default: begin
               if (is_digit) begin
                  n      = int'(number) * 10 + int'(b - tekd_pkg::CHAR_ZERO);
                  number = (n > int'(tekd_pkg::NUM_MAX)) ? tekd_pkg::NUM_MAX : 7'(n);
                  return 1'b0;
               end
               // the terminator itself is dropped
               phase         = tekd_pkg::PHASE_IDLE;
               ev.event_kind = tekd_pkg::EVENT_SPECIAL;
               case (number)
                  tekd_pkg::NUM_INSERT: ev.key_id = tekd_pkg::KEY_INSERT;
                  tekd_pkg::NUM_DELETE: ev.key_id = tekd_pkg::KEY_DELETE;
                  tekd_pkg::NUM_PGUP:   ev.key_id = tekd_pkg::KEY_PGUP;
                  tekd_pkg::NUM_PGDN:   ev.key_id = tekd_pkg::KEY_PGDN;
                  default:              ev.event_kind = tekd_pkg::EVENT_NONE;
               endcase
               return 1'b1;
            end
         endcase
      endfunction

      function void note_byte(input tekd_pkg::req_type item);
         tekd_pkg::rsp_type ev;
         bytes_seen++;
         if (decode_byte(item, ev))
            expected_events.push_back(ev);
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_event(input tekd_pkg::rsp_type got);
         tekd_pkg::rsp_type want;
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("event kind %0d char %h key %0d with none expected",
                                      got.event_kind, got.char_out, got.key_id));
            return;
         end
         want = expected_events.pop_front();
         events_checked++;
         if (got.event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind %0d, want %0d", got.event_kind,
                                      want.event_kind));
         if (got.char_out !== want.char_out)
            report_mismatch($sformatf("char_out %h, want %h", got.char_out, want.char_out));
         if (got.key_id !== want.key_id)
            report_mismatch($sformatf("key_id %0d, want %0d", got.key_id, want.key_id));
         case (want.event_kind)
            tekd_pkg::EVENT_CHAR: char_events++;
            tekd_pkg::EVENT_SPECIAL: begin
               key_events++;
               key_hit[want.key_id] = 1'b1;
            end
            default: none_events++;
         endcase
      endtask

      function int keys_covered();
         int count;
         count = 0;
         foreach (key_hit[i])
            if (key_hit[i])
               count++;
         return count;
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   tekd_pkg::req_type req_data  = '0;
   logic              rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   tekd_pkg::rsp_type rsp_data;

   int cycle_count = 0;
   int items_sent  = 0;
   int gap_pct     = 0;
   int stall_pct   = 0;
   bit quiet_tail  = 1'b0;

   key_event_tracker tracker = new();

   terminal_escape_key_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_byte(req_data);
         if (rsp_valid && !rsp_stall)
            tracker.check_event(rsp_data);
      end
   end

   // receiver back-pressure in bursts
   initial begin
      forever begin
         if (!quiet_tail && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic idle_for(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic push_byte(input logic [7:0] value, input logic pending);
      if (!quiet_tail && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
         idle_for($urandom_range(1, 11));
      req_valid <= 1'b1;
      req_data  <= '{byte_in: value, more_pending: pending};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_events();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_events.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_sequence();
      logic [7:0] intro;
      logic [7:0] key_letters[6];
      logic [6:0] key_numbers[4];
      int         pick;
      int         digits;
      int         r;
      key_letters = '{tekd_pkg::CHAR_A, tekd_pkg::CHAR_B, tekd_pkg::CHAR_C,
                      tekd_pkg::CHAR_D, tekd_pkg::CHAR_H, tekd_pkg::CHAR_F};
      key_numbers = '{tekd_pkg::NUM_INSERT, tekd_pkg::NUM_DELETE,
                      tekd_pkg::NUM_PGUP, tekd_pkg::NUM_PGDN};
      intro       = $urandom_range(0, 1) ? tekd_pkg::CHAR_BRACKET : tekd_pkg::CHAR_SS3;
      pick        = $urandom_range(0, 99);
      if (pick < 15) begin
         push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 20) begin
         push_byte(tekd_pkg::CHAR_CR, 1'($urandom_range(0, 1)));
      end else if (pick < 25) begin
         push_byte(tekd_pkg::CHAR_ESC, 1'b0);
      end else if (pick < 35) begin
         push_byte(tekd_pkg::CHAR_ESC, 1'b1);
         push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 55) begin
         push_byte(tekd_pkg::CHAR_ESC, 1'b1);
         push_byte(intro, 1'($urandom_range(0, 1)));
         push_byte(key_letters[$urandom_range(0, 5)], 1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
         r      = $urandom_range(0, 9);
         digits = (r < 6) ? 1 : (r < 8) ? 2 : (r < 9) ? 3 : $urandom_range(4, 5);
         push_byte(tekd_pkg::CHAR_ESC, 1'b1);
         push_byte(intro, 1'($urandom_range(0, 1)));
         if (digits == 1 && $urandom_range(0, 3) != 0) begin
            push_byte(tekd_pkg::CHAR_ZERO + {1'b0, key_numbers[$urandom_range(0, 3)]},
                      1'($urandom_range(0, 1)));
         end else begin
            repeat (digits)
               push_byte(tekd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)),
                         1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 9) < 7)
            push_byte(CHAR_TILDE, 1'($urandom_range(0, 1)));
         else
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
         push_byte(tekd_pkg::CHAR_ESC, 1'b1);
         push_byte(intro, 1'($urandom_range(0, 1)));
         push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
         // cut-off sequence: the next item lands in the middle of it
         push_byte(tekd_pkg::CHAR_ESC, 1'b1);
         if ($urandom_range(0, 1))
            push_byte(intro, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int random_start;
      int next_shift;
      bit drained;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain bytes at the extremes, CR mapping, lone ESC
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(tekd_pkg::CHAR_CR, 1'b0);
      push_byte(tekd_pkg::CHAR_ESC, 1'b0);
      // ESC-prefixed character keeps CR as is
      push_byte(tekd_pkg::CHAR_ESC, 1'b1);
      push_byte(tekd_pkg::CHAR_CR, 1'b0);
      push_byte(tekd_pkg::CHAR_ESC, 1'b1);
      push_byte(tekd_pkg::CHAR_BRACKET, 1'b0);
      push_byte(tekd_pkg::CHAR_A, 1'b1);
      push_byte(tekd_pkg::CHAR_ESC, 1'b1);
      push_byte(tekd_pkg::CHAR_SS3, 1'b1);
      push_byte(tekd_pkg::CHAR_F, 1'b0);
      // unknown final byte
      push_byte(tekd_pkg::CHAR_ESC, 1'b1);
      push_byte(tekd_pkg::CHAR_BRACKET, 1'b0);
      push_byte(8'h7A, 1'b0);
      push_byte(tekd_pkg::CHAR_ESC, 1'b1);
      push_byte(tekd_pkg::CHAR_BRACKET, 1'b1);
      push_byte(tekd_pkg::CHAR_ZERO + 8'(tekd_pkg::NUM_INSERT), 1'b1);
      push_byte(CHAR_TILDE, 1'b0);
      // saturating number, ended by an ESC that gets dropped
      push_byte(tekd_pkg::CHAR_ESC, 1'b1);
      push_byte(tekd_pkg::CHAR_BRACKET, 1'b1);
      push_byte(tekd_pkg::CHAR_NINE, 1'b1);
      push_byte(tekd_pkg::CHAR_NINE, 1'b0);
      push_byte(tekd_pkg::CHAR_NINE, 1'b1);
      push_byte(tekd_pkg::CHAR_ESC, 1'b1);
      wait_for_events();

      random_start = items_sent;
      next_shift   = 0;
      drained      = 1'b0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (items_sent - random_start >= next_shift) begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 10;
               default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 35;
            endcase
            next_shift += 50;
         end
         if (!drained && items_sent - random_start >= RANDOM_ITEMS / 2) begin
            wait_for_events();
            drained = 1'b1;
         end
         if (items_sent - random_start >= RANDOM_ITEMS - QUIET_ITEMS)
            quiet_tail = 1'b1;
         send_random_sequence();
      end

      wait_for_events();
      repeat (10) @(posedge clock);

      $display("decoded %0d bytes into %0d events: %0d characters, %0d keys, %0d none",
               tracker.bytes_seen, tracker.events_checked, tracker.char_events,
               tracker.key_events, tracker.none_events);
      $display("%0d of 10 special keys seen, %0d mismatches", tracker.keys_covered(),
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.expected_events.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- terminal_escape_key_decoder.f -----
+incdir+sv
sv/tekd_pkg.sv
sv/tekd_in_reg.sv
sv/tekd_parser.sv
sv/tekd_out_reg.sv
sv/terminal_escape_key_decoder.sv
sim/terminal_escape_key_decoder_tb.sv
